>>> hdl/samq_pkg.sv
// ----------------------------------------------------------------------------
// samq_pkg
// Types and constants for the sprite affine matrix quantizer.
// ----------------------------------------------------------------------------
package samq_pkg;

	localparam int CORDIC_STEPS = 28;

	localparam logic signed [33:0] Q28_PI      = 34'sd843314857;
	localparam logic signed [33:0] Q28_TWO_PI  = 34'sd1686629713;
	localparam logic signed [33:0] Q28_HALF_PI = 34'sd421657428;
	localparam logic signed [32:0] Q30_GAIN    = 33'sd652032874;

	localparam logic signed [31:0] ONE_Q10 = 32'sd1024;

	localparam logic signed [33:0] ATAN_Q28 [CORDIC_STEPS] = '{
		34'sd210828714, 34'sd124459457, 34'sd65760959, 34'sd33381290,
		34'sd16755422, 34'sd8385879, 34'sd4193963, 34'sd2097109,
		34'sd1048571, 34'sd524287, 34'sd262144, 34'sd131072,
		34'sd65536, 34'sd32768, 34'sd16384, 34'sd8192, 34'sd4096,
		34'sd2048, 34'sd1024, 34'sd512, 34'sd256, 34'sd128, 34'sd64,
		34'sd32, 34'sd16, 34'sd8, 34'sd4, 34'sd2
	};

	typedef struct packed {
		logic signed [16:0] sx;
		logic signed [16:0] sy;
		logic signed [15:0] kx;
		logic signed [15:0] ky;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic               ident;
	} side_t;

	// trunc((v + 2^35) / 2^36) toward zero
	function automatic logic signed [31:0] quant_lin(input logic signed [67:0] v);
		logic signed [67:0] w;
		logic signed [67:0] q;
		begin
			w = v + (68'sd1 <<< 35);
			q = w >>> 36;
			if (w[67] && (w[35:0] != 36'd0))
				q = q + 68'sd1;
			return q[31:0];
		end
	endfunction

	// trunc((v + 8) / 16) toward zero
	function automatic logic signed [31:0] quant_pos(input logic signed [23:0] v);
		logic signed [24:0] w;
		logic signed [24:0] q;
		begin
			w = 25'(v) + 25'sd8;
			q = w >>> 4;
			if (w[24] && (w[3:0] != 4'd0))
				q = q + 25'sd1;
			return 32'(q);
		end
	endfunction

endpackage

>>> hdl/sprite_affine_matrix_quantizer_top.sv
// ----------------------------------------------------------------------------
// sprite_affine_matrix_quantizer_top
// Builds the quantized 2D affine matrix of one sprite per beat.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one sprite per beat: centre, scale,
// shear, angle, mirror, leaf and force flags. Output channel
// out_valid/out_stall carries the four linear terms (times 1024) and the
// translation (times 16, y negated). A leaf sprite without force gives the
// identity matrix.
// The pipeline has two angle reduction stages, one stage per CORDIC
// iteration (28), one sign stage and four multiply / sum / quantize stages.
// Throughput is one beat per cycle while the output is not stalled.
// The whole pipeline advances together; when out_valid is high and
// out_stall is high, every stage holds and in_stall is raised, so nothing is
// lost or repeated. Bubbles move forward while the output is empty or taken.
// Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module sprite_affine_matrix_quantizer_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] center_x,
	input  logic signed [23:0] center_y,
	input  logic signed [15:0] scale_x,
	input  logic signed [15:0] scale_y,
	input  logic signed [15:0] shear_x,
	input  logic signed [15:0] shear_y,
	input  logic signed [15:0] angle,
	input  logic               mirror_x,
	input  logic               mirror_y,
	input  logic               is_leaf,
	input  logic               force_full,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] m00,
	output logic signed [31:0] m01,
	output logic signed [31:0] m10,
	output logic signed [31:0] m11,
	output logic signed [31:0] tx,
	output logic signed [31:0] ty
);

	localparam int N = samq_pkg::CORDIC_STEPS;

	logic en;

	// stage 1: negate angle to Q.28, reduce by 2pi
	logic signed [33:0]  t_raw;
	logic signed [33:0]  t_red;
	samq_pkg::side_t     side_in;
	logic                vld_s1;
	logic signed [33:0]  t_s1;
	samq_pkg::side_t     side_s1;

	// stage 2: reduce to half pi
	logic                vld_s2;
	logic signed [33:0]  t_s2;
	logic                neg_s2;
	samq_pkg::side_t     side_s2;

	// CORDIC stages
	logic                vld_sc  [N+1];
	logic signed [32:0]  x_sc    [N+1];
	logic signed [32:0]  y_sc    [N+1];
	logic signed [33:0]  z_sc    [N+1];
	logic                neg_sc  [N+1];
	samq_pkg::side_t     side_sc [N+1];

	// stage 3: apply sign
	logic                vld_s3;
	logic signed [32:0]  c_s3;
	logic signed [32:0]  s_s3;
	samq_pkg::side_t     side_s3;

	// stage 4: first products
	logic                vld_s4;
	logic signed [49:0]  sxc_s4, sxs_s4, syc_s4, sys_s4;
	logic signed [32:0]  ksy_s4, kysx_s4;
	logic signed [32:0]  c_s4, s_s4;
	samq_pkg::side_t     side_s4;

	// stage 5: second products
	logic                vld_s5;
	logic signed [67:0]  a1_s5, b1_s5, c1_s5, d1_s5;
	logic signed [67:0]  a2_s5, b2_s5, c2_s5, d2_s5;
	samq_pkg::side_t     side_s5;

	// stage 6: sums
	logic                vld_s6;
	logic signed [67:0]  a_s6, b_s6, c_s6, d_s6;
	samq_pkg::side_t     side_s6;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_comb begin
		t_raw = -(34'(angle) <<< 16);
		if (t_raw > samq_pkg::Q28_PI)
			t_red = t_raw - samq_pkg::Q28_TWO_PI;
		else if (t_raw < -samq_pkg::Q28_PI)
			t_red = t_raw + samq_pkg::Q28_TWO_PI;
		else
			t_red = t_raw;
		side_in.sx    = mirror_x ? -17'(scale_x) : 17'(scale_x);
		side_in.sy    = mirror_y ? -17'(scale_y) : 17'(scale_y);
		side_in.kx    = shear_x;
		side_in.ky    = shear_y;
		side_in.tx    = samq_pkg::quant_pos(center_x);
		side_in.ty    = -samq_pkg::quant_pos(center_y);
		side_in.ident = is_leaf && !force_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_sc[N];
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			out_valid <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= t_red;
			side_s1 <= side_in;

			if (t_s1 > samq_pkg::Q28_HALF_PI) begin
				t_s2   <= t_s1 - samq_pkg::Q28_PI;
				neg_s2 <= 1'b1;
			end else if (t_s1 < -samq_pkg::Q28_HALF_PI) begin
				t_s2   <= t_s1 + samq_pkg::Q28_PI;
				neg_s2 <= 1'b1;
			end else begin
				t_s2   <= t_s1;
				neg_s2 <= 1'b0;
			end
			side_s2 <= side_s1;

			c_s3    <= neg_sc[N] ? -x_sc[N] : x_sc[N];
			s_s3    <= neg_sc[N] ? -y_sc[N] : y_sc[N];
			side_s3 <= side_sc[N];

			sxc_s4  <= 50'(side_s3.sx) * 50'(c_s3);
			sxs_s4  <= 50'(side_s3.sx) * 50'(s_s3);
			syc_s4  <= 50'(side_s3.sy) * 50'(c_s3);
			sys_s4  <= 50'(side_s3.sy) * 50'(s_s3);
			ksy_s4  <= 33'(side_s3.kx) * 33'(side_s3.sy);
			kysx_s4 <= 33'(side_s3.ky) * 33'(side_s3.sx);
			c_s4    <= c_s3;
			s_s4    <= s_s3;
			side_s4 <= side_s3;

			a1_s5   <= 68'(sxc_s4) <<< 8;
			b1_s5   <= 68'(sxs_s4) <<< 8;
			c1_s5   <= 68'(sys_s4) <<< 8;
			d1_s5   <= 68'(syc_s4) <<< 8;
			a2_s5   <= 68'(ksy_s4) * 68'(s_s4);
			b2_s5   <= 68'(ksy_s4) * 68'(c_s4);
			c2_s5   <= 68'(kysx_s4) * 68'(c_s4);
			d2_s5   <= 68'(kysx_s4) * 68'(s_s4);
			side_s5 <= side_s4;

			a_s6    <= a1_s5 - a2_s5;
			b_s6    <= b1_s5 + b2_s5;
			c_s6    <= c2_s5 - c1_s5;
			d_s6    <= d2_s5 + d1_s5;
			side_s6 <= side_s5;

			if (side_s6.ident) begin
				m00 <= samq_pkg::ONE_Q10;
				m01 <= '0;
				m10 <= '0;
				m11 <= samq_pkg::ONE_Q10;
				tx  <= '0;
				ty  <= '0;
			end else begin
				m00 <= samq_pkg::quant_lin(a_s6);
				m01 <= samq_pkg::quant_lin(b_s6);
				m10 <= samq_pkg::quant_lin(c_s6);
				m11 <= samq_pkg::quant_lin(d_s6);
				tx  <= side_s6.tx;
				ty  <= side_s6.ty;
			end
		end
	end

	assign vld_sc[0]  = vld_s2;
	assign x_sc[0]    = samq_pkg::Q30_GAIN;
	assign y_sc[0]    = '0;
	assign z_sc[0]    = t_s2;
	assign neg_sc[0]  = neg_s2;
	assign side_sc[0] = side_s2;

	for (genvar i = 0; i < N; i++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_sc[i+1] <= 1'b0;
			else if (en)
				vld_sc[i+1] <= vld_sc[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_sc[i][33]) begin
					x_sc[i+1] <= x_sc[i] - (y_sc[i] >>> i);
					y_sc[i+1] <= y_sc[i] + (x_sc[i] >>> i);
					z_sc[i+1] <= z_sc[i] - samq_pkg::ATAN_Q28[i];
				end else begin
					x_sc[i+1] <= x_sc[i] + (y_sc[i] >>> i);
					y_sc[i+1] <= y_sc[i] - (x_sc[i] >>> i);
					z_sc[i+1] <= z_sc[i] + samq_pkg::ATAN_Q28[i];
				end
				neg_sc[i+1]  <= neg_sc[i];
				side_sc[i+1] <= side_sc[i];
			end
		end
	end

endmodule

>>> hdl/samq_checker.sv
// ----------------------------------------------------------------------------
// samq_checker
// Port-level checks for the sprite affine matrix quantizer.
// ----------------------------------------------------------------------------
module samq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] m00,
	input logic signed [31:0] ty
);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled output beat");

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is free");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("output beat dropped under stall");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(m00) && $stable(ty)))
		else $error("output beat changed under stall");

endmodule

bind sprite_affine_matrix_quantizer_top samq_checker u_samq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.m00       (m00),
	.ty        (ty)
);
